// ----- design/vitr_pkg.sv -----
// Shared types and constants of the video interface timing register block.
// Used by the controller, datapath, divider and top level; no dependencies.

package vitr_pkg;

  // register file depth and fixed register places
  localparam int REG_COUNT   = 14;
  localparam int IDX_STATUS  = 0;
  localparam int IDX_WIDTH   = 2;
  localparam int IDX_CURRENT = 4;
  localparam int IDX_VSYNC   = 6;

  // status bit that enables interlace field toggling
  localparam int STATUS_INTERLACE_BIT = 6;

  // field widths
  localparam int WORD_W   = 32;
  localparam int IDX_W    = 4;
  localparam int KIND_W   = 2;
  localparam int CLK_HZ_W = 27;
  localparam int RATE_W   = 7;
  localparam int CFG_ADDR_W = 1;
  localparam int CFG_DATA_W = 27;

  // stream widths, packed fields padded to whole bytes
  localparam int IN_BITS   = IDX_W + 3 * WORD_W;
  localparam int IN_DATA_W = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_BITS  = 2 * WORD_W + 6;
  localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

  // configuration register indexes and reset values
  localparam logic [CFG_ADDR_W-1:0] CFG_VIDEO_CLOCK_HZ = 1'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_REFRESH_RATE   = 1'd1;
  localparam logic [CLK_HZ_W-1:0]   CLK_HZ_RESET  = 27'd48681812;
  localparam logic [RATE_W-1:0]     REFRESH_RESET = 7'd60;

  // request kinds
  localparam logic [KIND_W-1:0] REQ_READ  = 2'd0;
  localparam logic [KIND_W-1:0] REQ_WRITE = 2'd1;
  localparam logic [KIND_W-1:0] REQ_TICK  = 2'd2;
  localparam logic [KIND_W-1:0] REQ_NOP   = 2'd3;

  // divider operand selection
  typedef enum logic [1:0] {
    DIV_PER_FRAME,
    DIV_PER_LINE,
    DIV_LINE
  } div_sel_t;

  // controller to datapath commands
  typedef struct packed {
    logic     div_start;
    div_sel_t div_sel;
    logic     mul_en;
    logic     commit;
  } dp_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic vsync_write;
    logic line_divide;
    logic div_done;
    logic out_stall;
  } dp_stat_t;

  // one result item
  typedef struct packed {
    logic              frame_done;
    logic              width_changed;
    logic              status_changed;
    logic [WORD_W-1:0] schedule_count;
    logic              schedule_valid;
    logic              irq_clear;
    logic              irq_raise;
    logic [WORD_W-1:0] read_data;
  } result_t;

endpackage

// ----- design/vitr_div.sv -----
// Restoring divider, one quotient bit per cycle, 32-bit dividend by 33-bit divisor.
// A zero divisor gives a zero quotient. Uses vitr_pkg.

module vitr_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [vitr_pkg::WORD_W-1:0] dividend,
  input  logic [vitr_pkg::WORD_W:0]   divisor,
  output logic                       done,
  output logic [vitr_pkg::WORD_W-1:0] quotient
);

  localparam int W     = vitr_pkg::WORD_W;
  localparam int CNT_W = $clog2(W);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [W:0]       rem;
  logic [W-1:0]     quo;
  logic [W:0]       dvs;
  logic             zero;
  logic [W+1:0]     shifted;
  logic [W+1:0]     diff;
  logic             fits;

  // one trial subtraction per step
  assign shifted = {rem, quo[W-1]};
  assign diff    = shifted - {1'b0, dvs};
  assign fits    = shifted >= {1'b0, dvs};

  // iteration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(W - 1);
        rem  <= '0;
        quo  <= dividend;
        dvs  <= divisor;
        zero <= (divisor == '0);
      end else if (busy) begin
        rem <= fits ? diff[W:0] : shifted[W:0];
        quo <= {quo[W-2:0], fits};
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient = zero ? '0 : quo;

endmodule

// ----- design/vitr_dp.sv -----
// Datapath: request latch, register file, frame timing state, shared divider,
// multiplier and result register. Uses vitr_pkg and vitr_div.

module vitr_dp #(
  parameter int REG_COUNT = vitr_pkg::REG_COUNT
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [vitr_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  logic [vitr_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  input  logic                              in_fire,
  input  logic [vitr_pkg::KIND_W-1:0]       in_kind,
  input  logic [vitr_pkg::IDX_W-1:0]        in_idx,
  input  logic [vitr_pkg::WORD_W-1:0]       in_data,
  input  logic [vitr_pkg::WORD_W-1:0]       in_mask,
  input  logic [vitr_pkg::WORD_W-1:0]       in_now,
  input  vitr_pkg::dp_cmd_t                 cmd,
  output vitr_pkg::dp_stat_t                stat,
  input  logic                              out_ready,
  output logic                              out_valid,
  output vitr_pkg::result_t                 out_res
);

  localparam int W    = vitr_pkg::WORD_W;
  localparam int IDXW = $clog2(REG_COUNT);

  // configuration
  logic [vitr_pkg::CLK_HZ_W-1:0] video_clock_hz;
  logic [vitr_pkg::RATE_W-1:0]   refresh_rate;

  // latched request
  logic [vitr_pkg::KIND_W-1:0] req_kind;
  logic [vitr_pkg::IDX_W-1:0]  req_idx;
  logic [W-1:0]                req_data;
  logic [W-1:0]                req_mask;
  logic [W-1:0]                req_now;

  // block state
  logic [W-1:0] rf [REG_COUNT];
  logic         interlace_field;
  logic [W-1:0] frame_delay;
  logic [W-1:0] next_frame_count;
  logic [W-1:0] cycles_per_line;
  logic [W-1:0] prod;

  // divider hookup
  logic [W-1:0] div_dividend;
  logic [W:0]   div_divisor;
  logic         div_done;
  logic [W-1:0] quot;

  logic              in_file;
  logic [W-1:0]      rd_word;
  logic [W-1:0]      merged;
  logic              differs;
  logic [W-1:0]      vs_cur;
  logic [W-1:0]      vs_new;
  logic [W:0]        lines;
  logic [W-1:0]      elapsed;
  logic [W-1:0]      line_raw;
  logic [W-1:0]      line_wrap;
  logic [W-1:0]      line_val;
  logic [W-1:0]      fd_new;
  logic [W-1:0]      sched_new;
  logic              is_status;
  logic              is_width;
  logic              is_current;
  logic              is_vsync;
  vitr_pkg::result_t res_next;

  // register decode
  assign in_file    = {1'b0, req_idx} < (vitr_pkg::IDX_W + 1)'(REG_COUNT);
  assign rd_word    = rf[req_idx[IDXW-1:0]];
  assign merged     = (rd_word & ~req_mask) | (req_data & req_mask);
  assign differs    = (rd_word & req_mask) != (req_data & req_mask);
  assign is_status  = req_idx == vitr_pkg::IDX_W'(vitr_pkg::IDX_STATUS);
  assign is_width   = req_idx == vitr_pkg::IDX_W'(vitr_pkg::IDX_WIDTH);
  assign is_current = req_idx == vitr_pkg::IDX_W'(vitr_pkg::IDX_CURRENT);
  assign is_vsync   = req_idx == vitr_pkg::IDX_W'(vitr_pkg::IDX_VSYNC);

  // vsync and line arithmetic
  assign vs_cur    = rf[vitr_pkg::IDX_VSYNC];
  assign vs_new    = (vs_cur & ~req_mask) | (req_data & req_mask);
  assign lines     = {1'b0, vs_new} + (W + 1)'(1);
  assign elapsed   = frame_delay - (next_frame_count - req_now);
  assign line_raw  = (vs_cur != '0) ? quot : rf[vitr_pkg::IDX_CURRENT];
  assign line_wrap = (line_raw >= vs_cur) ? line_raw - vs_cur : line_raw;
  assign line_val  = {line_wrap[W-1:1], interlace_field};
  assign fd_new    = prod + quot;
  assign sched_new = req_now + fd_new;

  // divider operand selection
  always_comb begin
    case (cmd.div_sel)
      vitr_pkg::DIV_PER_FRAME: begin
        div_dividend = W'(video_clock_hz);
        div_divisor  = (W + 1)'(refresh_rate);
      end
      vitr_pkg::DIV_PER_LINE: begin
        div_dividend = quot;
        div_divisor  = lines;
      end
      vitr_pkg::DIV_LINE: begin
        div_dividend = elapsed;
        div_divisor  = {1'b0, cycles_per_line};
      end
      default: begin
        div_dividend = '0;
        div_divisor  = '0;
      end
    endcase
  end

  vitr_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (quot)
  );

  // status to the controller
  assign stat.vsync_write = (req_kind == vitr_pkg::REQ_WRITE) && in_file && is_vsync;
  assign stat.line_divide = (req_kind == vitr_pkg::REQ_READ) && in_file && is_current
                            && (vs_cur != '0);
  assign stat.div_done    = div_done;
  assign stat.out_stall   = out_valid && !out_ready;

  // result of the current request
  always_comb begin
    res_next = '0;
    case (req_kind)
      vitr_pkg::REQ_READ: begin
        if (in_file) res_next.read_data = is_current ? line_val : rd_word;
      end
      vitr_pkg::REQ_WRITE: begin
        if (in_file) begin
          if (is_status) res_next.status_changed = differs;
          if (is_width) res_next.width_changed = differs;
          if (is_current) res_next.irq_clear = 1'b1;
          if (is_vsync && vs_new != '0 && next_frame_count == '0) begin
            res_next.schedule_valid = 1'b1;
            res_next.schedule_count = sched_new;
          end
        end
      end
      vitr_pkg::REQ_TICK: begin
        res_next.irq_raise      = 1'b1;
        res_next.schedule_valid = 1'b1;
        res_next.schedule_count = next_frame_count + frame_delay;
        res_next.frame_done     = 1'b1;
      end
      default: res_next = '0;
    endcase
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      video_clock_hz <= vitr_pkg::CLK_HZ_RESET;
      refresh_rate   <= vitr_pkg::REFRESH_RESET;
    end else if (cfg_we) begin
      case (cfg_addr)
        vitr_pkg::CFG_VIDEO_CLOCK_HZ: video_clock_hz <= cfg_wdata;
        vitr_pkg::CFG_REFRESH_RATE:   refresh_rate <= cfg_wdata[vitr_pkg::RATE_W-1:0];
        default: ;
      endcase
    end
  end

  // request latch and multiplier stage
  always_ff @(posedge clk) begin
    if (in_fire) begin
      req_kind <= in_kind;
      req_idx  <= in_idx;
      req_data <= in_data;
      req_mask <= in_mask;
      req_now  <= in_now;
    end
    if (cmd.mul_en) prod <= vs_new * quot;
  end

  // state update on commit
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < REG_COUNT; i++) rf[i] <= '0;
      interlace_field  <= 1'b0;
      frame_delay      <= '0;
      next_frame_count <= '0;
      cycles_per_line  <= '0;
    end else if (cmd.commit) begin
      case (req_kind)
        vitr_pkg::REQ_READ: begin
          if (in_file && is_current) rf[vitr_pkg::IDX_CURRENT] <= line_val;
        end
        vitr_pkg::REQ_WRITE: begin
          if (in_file) begin
            if (is_status || is_width) begin
              if (differs) rf[req_idx[IDXW-1:0]] <= merged;
            end else if (is_vsync) begin
              rf[vitr_pkg::IDX_VSYNC] <= vs_new;
              cycles_per_line <= quot;
              frame_delay     <= fd_new;
              if (vs_new != '0 && next_frame_count == '0) next_frame_count <= sched_new;
            end else if (!is_current) begin
              rf[req_idx[IDXW-1:0]] <= merged;
            end
          end
        end
        vitr_pkg::REQ_TICK: begin
          interlace_field  <= interlace_field
                              ^ rf[vitr_pkg::IDX_STATUS][vitr_pkg::STATUS_INTERLACE_BIT];
          next_frame_count <= next_frame_count + frame_delay;
        end
        default: ;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (cmd.commit) out_res <= res_next;
  end

endmodule

// ----- design/vitr_ctrl.sv -----
// Controller: sequences accept, divisions, multiply and commit of one request.
// Uses vitr_pkg command and status types.

module vitr_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_fire,
  input  vitr_pkg::dp_stat_t stat,
  output logic               ready,
  output vitr_pkg::dp_cmd_t  cmd
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_PF_WAIT,
    ST_CPL_WAIT,
    ST_LINE_WAIT,
    ST_WRITEBACK
  } state_t;

  state_t state;

  // state and registered commands
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      ready       <= 1'b0;
      cmd.div_start <= 1'b0;
      cmd.div_sel <= vitr_pkg::DIV_PER_FRAME;
      cmd.mul_en  <= 1'b0;
      cmd.commit  <= 1'b0;
    end else begin
      cmd.div_start <= 1'b0;
      cmd.mul_en    <= 1'b0;
      cmd.commit    <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (in_fire) begin
            ready <= 1'b0;
            state <= ST_DECODE;
          end else begin
            ready <= 1'b1;
          end
        end
        ST_DECODE: begin
          if (stat.vsync_write) begin
            cmd.div_start <= 1'b1;
            cmd.div_sel   <= vitr_pkg::DIV_PER_FRAME;
            state         <= ST_PF_WAIT;
          end else if (stat.line_divide) begin
            cmd.div_start <= 1'b1;
            cmd.div_sel   <= vitr_pkg::DIV_LINE;
            state         <= ST_LINE_WAIT;
          end else begin
            state <= ST_WRITEBACK;
          end
        end
        ST_PF_WAIT: begin
          if (stat.div_done) begin
            cmd.div_start <= 1'b1;
            cmd.div_sel   <= vitr_pkg::DIV_PER_LINE;
            state         <= ST_CPL_WAIT;
          end
        end
        ST_CPL_WAIT: begin
          if (stat.div_done) begin
            cmd.mul_en <= 1'b1;
            state      <= ST_WRITEBACK;
          end
        end
        ST_LINE_WAIT: begin
          if (stat.div_done) state <= ST_WRITEBACK;
        end
        ST_WRITEBACK: begin
          if (!stat.out_stall) begin
            cmd.commit <= 1'b1;
            ready      <= 1'b1;
            state      <= ST_IDLE;
          end
        end
        default: begin
          ready <= 1'b1;
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- design/video_interface_timing_registers_unit.sv -----
// Video interface timing register block: stream request in, one result beat out.
// Uses vitr_pkg, vitr_ctrl and vitr_dp.
//
// Each input beat is one request (read, masked write, vertical tick or no-op)
// with the current processor cycle count; each yields exactly one output beat.
// The configuration port writes the video clock rate (index 0) and the refresh
// rate (index 1); the user must write them only while no request is in flight,
// as the block itself does not enforce this.
// The pace is set by the shared 32-step restoring divider: one division per
// current-line read with a nonzero vsync, two chained ones plus a multiply per
// vsync write.
// One request is in work at a time; the next beat is taken once the previous
// one has gone to the result register.
// Reset clears the register file and timing state and restores the default
// clock and refresh rates. A stalled receiver holds the result register; the
// block still takes the next request and holds its result until room appears.

module video_interface_timing_registers_unit #(
  parameter int REG_COUNT = vitr_pkg::REG_COUNT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [vitr_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  logic [vitr_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // reg_index, write_data, write_mask, cycle_count, zero pad
  input  logic [vitr_pkg::IN_DATA_W-1:0]      s_axis_tdata,
  // req_type
  input  logic [vitr_pkg::KIND_W-1:0]         s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // read_data, irq_raise, irq_clear, schedule_valid, schedule_count,
  // status_changed, width_changed, frame_done, zero pad
  output logic [vitr_pkg::OUT_DATA_W-1:0]     m_axis_tdata
);

  localparam int W  = vitr_pkg::WORD_W;
  localparam int IW = vitr_pkg::IDX_W;

  logic               in_fire;
  vitr_pkg::dp_cmd_t  cmd;
  vitr_pkg::dp_stat_t stat;
  vitr_pkg::result_t  res;

  // input beat handshake
  assign in_fire = s_axis_tvalid && s_axis_tready;

  vitr_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_fire (in_fire),
    .stat    (stat),
    .ready   (s_axis_tready),
    .cmd     (cmd)
  );

  vitr_dp #(
    .REG_COUNT (REG_COUNT)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_fire   (in_fire),
    .in_kind   (s_axis_tuser),
    .in_idx    (s_axis_tdata[IW-1:0]),
    .in_data   (s_axis_tdata[IW+W-1:IW]),
    .in_mask   (s_axis_tdata[IW+2*W-1:IW+W]),
    .in_now    (s_axis_tdata[IW+3*W-1:IW+2*W]),
    .cmd       (cmd),
    .stat      (stat),
    .out_ready (m_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_res   (res)
  );

  // output beat packing, padded to whole bytes
  assign m_axis_tdata = vitr_pkg::OUT_DATA_W'({res.frame_done, res.width_changed,
                                               res.status_changed, res.schedule_count,
                                               res.schedule_valid, res.irq_clear,
                                               res.irq_raise, res.read_data});

endmodule

// ----- sim/video_interface_timing_registers_unit_tb.sv -----
// Self-checking testbench for the video interface timing register block.
// Needs vitr_pkg and video_interface_timing_registers_unit; a directed table
// then random requests, checked against hand-written values or a cycle-free predictor.

module video_interface_timing_registers_unit_tb;
  import vitr_pkg::*;

  localparam int CYCLE_LIMIT  = 600000;
  localparam int PHASE_ITEMS  = 155;
  localparam int PHASE_COUNT  = 7;
  localparam int SETTLE       = 8;
  localparam int TAIL_CYCLES  = 100;
  localparam int TABLE_ROWS   = 26;
  localparam logic [31:0] ALL_ONES = 32'hFFFF_FFFF;

  // hand-written expectations for the directed table
  localparam result_t RES_NONE = '0;
  localparam result_t RES_TICK_AT_ZERO =
    '{irq_raise: 1'b1, schedule_valid: 1'b1, frame_done: 1'b1, default: '0};
  localparam result_t RES_IRQ_CLEAR  = '{irq_clear: 1'b1, default: '0};
  localparam result_t RES_STATUS_CHG = '{status_changed: 1'b1, default: '0};
  localparam result_t RES_WIDTH_CHG  = '{width_changed: 1'b1, default: '0};

  typedef struct {
    logic [KIND_W-1:0] kind;
    logic [IDX_W-1:0]  idx;
    logic [31:0]       data;
    logic [31:0]       mask;
    logic [31:0]       now;
    logic              typed;
    result_t           want;
  } req_row_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_we;
  logic [CFG_ADDR_W-1:0] cfg_addr;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata;
  logic [KIND_W-1:0]     s_axis_tuser;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;

  // predictor state
  logic [31:0]         reg_shadow [REG_COUNT];
  logic                field_bit;
  logic [31:0]         frame_span;
  logic [31:0]         next_frame;
  logic [31:0]         line_cycles;
  logic [CLK_HZ_W-1:0] clk_hz;
  logic [RATE_W-1:0]   fps;

  result_t  pending_results [$];
  req_row_t directed_rows [TABLE_ROWS];
  int       fail_count;
  int       cycle_count;
  int       beats_checked;
  int       line_reads;
  int       vsync_writes;
  int       ticks;
  int       requests;
  int       burst_left;
  logic     valid_held;
  int       rx_phase;

  video_interface_timing_registers_unit i_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_addr      (cfg_addr),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // register access with frame timing, one result per request
  function automatic result_t video_reg_access(input logic [KIND_W-1:0] kind,
      input logic [IDX_W-1:0] idx, input logic [31:0] data, input logic [31:0] mask,
      input logic [31:0] now);
    result_t     res;
    logic [31:0] vsync;
    logic [31:0] line;
    logic [31:0] elapsed;
    logic [31:0] per_frame;
    logic [32:0] lines;
    logic [63:0] span;
    int          slot;
    res = '0;
    slot = int'(idx);
    case (kind)
      REQ_READ: begin
        if (slot == IDX_CURRENT) begin
          vsync = reg_shadow[IDX_VSYNC];
          line = reg_shadow[IDX_CURRENT];
          if (vsync != 0) begin
            elapsed = frame_span - (next_frame - now);
            line = (line_cycles != 0) ? elapsed / line_cycles : 32'd0;
          end
          // single wrap at vsync, field in bit 0
          if (line >= vsync) line = line - vsync;
          line = {line[31:1], field_bit};
          reg_shadow[IDX_CURRENT] = line;
          res.read_data = line;
        end else if (slot < REG_COUNT) begin
          res.read_data = reg_shadow[slot];
        end
      end
      REQ_WRITE: begin
        if (slot < REG_COUNT) begin
          if (slot == IDX_STATUS || slot == IDX_WIDTH) begin
            if ((reg_shadow[slot] & mask) != (data & mask)) begin
              reg_shadow[slot] = (reg_shadow[slot] & ~mask) | (data & mask);
              if (slot == IDX_STATUS) res.status_changed = 1'b1;
              else res.width_changed = 1'b1;
            end
          end else if (slot == IDX_CURRENT) begin
            res.irq_clear = 1'b1;
          end else if (slot == IDX_VSYNC) begin
            // line count needs 33 bits, frame span wraps at 32
            vsync = (reg_shadow[IDX_VSYNC] & ~mask) | (data & mask);
            lines = {1'b0, vsync} + 33'd1;
            per_frame = (fps != 0) ? 32'(clk_hz) / 32'(fps) : 32'd0;
            reg_shadow[IDX_VSYNC] = vsync;
            line_cycles = 32'({1'b0, per_frame} / lines);
            span = {31'd0, lines} * {32'd0, line_cycles};
            frame_span = span[31:0];
            if (vsync != 0 && next_frame == 0) begin
              next_frame = now + frame_span;
              res.schedule_valid = 1'b1;
              res.schedule_count = next_frame;
            end
          end else begin
            reg_shadow[slot] = (reg_shadow[slot] & ~mask) | (data & mask);
          end
        end
      end
      REQ_TICK: begin
        field_bit = field_bit ^ reg_shadow[IDX_STATUS][STATUS_INTERLACE_BIT];
        next_frame = next_frame + frame_span;
        res.irq_raise = 1'b1;
        res.schedule_valid = 1'b1;
        res.schedule_count = next_frame;
        res.frame_done = 1'b1;
      end
      default: ;
    endcase
    return res;
  endfunction

  // send one request beat, predict on accept, then maybe pause the sender
  task automatic push_request(input logic [KIND_W-1:0] kind, input logic [IDX_W-1:0] idx,
      input logic [31:0] data, input logic [31:0] mask, input logic [31:0] now,
      input logic typed, input result_t want);
    result_t predicted;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= IN_DATA_W'({now, mask, data, idx});
    valid_held = 1'b1;
    do @(posedge clk); while (!s_axis_tready);
    requests++;
    if (kind == REQ_READ && int'(idx) == IDX_CURRENT && reg_shadow[IDX_VSYNC] != 0)
      line_reads++;
    if (kind == REQ_WRITE && int'(idx) == IDX_VSYNC) vsync_writes++;
    if (kind == REQ_TICK) ticks++;
    predicted = video_reg_access(kind, idx, data, mask, now);
    pending_results.push_back(typed ? want : predicted);
    burst_left--;
    if (burst_left <= 0) begin
      s_axis_tvalid <= 1'b0;
      valid_held = 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                               : $urandom_range(1, 8);
    end
  endtask

  // stop sending and let every outstanding result drain
  task automatic wait_idle();
    if (valid_held) begin
      s_axis_tvalid <= 1'b0;
      valid_held = 1'b0;
    end
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_timing(input logic [CLK_HZ_W-1:0] hz, input logic [RATE_W-1:0] rate);
    cfg_we    <= 1'b1;
    cfg_addr  <= CFG_VIDEO_CLOCK_HZ;
    cfg_wdata <= hz;
    @(posedge clk);
    cfg_addr  <= CFG_REFRESH_RATE;
    cfg_wdata <= CFG_DATA_W'(rate);
    @(posedge clk);
    cfg_we <= 1'b0;
    clk_hz = hz;
    fps = rate;
  endtask

  // weighted random request, mostly timing traffic with plausible cycle counts
  task automatic random_request();
    int          pick;
    int          sel;
    logic [31:0] data;
    logic [31:0] mask;
    logic [31:0] now;
    pick = $urandom_range(0, 99);
    data = $urandom;
    mask = $urandom;
    now = $urandom;
    if (pick < 30) begin
      if (frame_span != 0 && $urandom_range(0, 3) != 0)
        now = next_frame - $urandom_range(0, frame_span);
      push_request(REQ_READ, IDX_W'(IDX_CURRENT), data, mask, now, 1'b0, RES_NONE);
    end else if (pick < 45) begin
      push_request(REQ_TICK, IDX_W'($urandom), data, mask, now, 1'b0, RES_NONE);
    end else if (pick < 60) begin
      sel = $urandom_range(0, 9);
      if (sel < 6) begin
        data = $urandom_range(1, 700);
        mask = ALL_ONES;
      end else if (sel == 6) begin
        data = $urandom_range(1, 65535);
        mask = ALL_ONES;
      end else if (sel == 7) begin
        data = ($urandom_range(0, 1) == 0) ? 32'd0 : ALL_ONES;
        mask = ALL_ONES;
      end
      push_request(REQ_WRITE, IDX_W'(IDX_VSYNC), data, mask, now, 1'b0, RES_NONE);
    end else if (pick < 70) begin
      push_request(REQ_WRITE, IDX_W'(IDX_STATUS), data, mask, now, 1'b0, RES_NONE);
    end else if (pick < 75) begin
      push_request(REQ_WRITE, IDX_W'(IDX_WIDTH), data, mask, now, 1'b0, RES_NONE);
    end else if (pick < 80) begin
      push_request(REQ_WRITE, IDX_W'(IDX_CURRENT), data, mask, now, 1'b0, RES_NONE);
    end else if (pick < 90) begin
      push_request(REQ_READ, IDX_W'($urandom), data, mask, now, 1'b0, RES_NONE);
    end else if (pick < 95) begin
      push_request(REQ_WRITE, IDX_W'($urandom), data, mask, now, 1'b0, RES_NONE);
    end else begin
      push_request(REQ_NOP, IDX_W'($urandom), data, mask, now, 1'b0, RES_NONE);
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
      input logic [31:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
      fail_count++;
    end
  endtask

  // result side: compare each beat, stall on a rotating pattern
  always @(posedge clk) begin : result_monitor
    result_t want;
    result_t got;
    rx_phase <= rx_phase + 1;
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = result_t'(m_axis_tdata[OUT_BITS-1:0]);
        if (pending_results.size() == 0) begin
          $error("result beat with no request outstanding: 0x%0h", got);
          fail_count++;
        end else begin
          want = pending_results.pop_front();
          beats_checked++;
          check_field("read_data", want.read_data, got.read_data);
          check_field("irq_raise", 32'(want.irq_raise), 32'(got.irq_raise));
          check_field("irq_clear", 32'(want.irq_clear), 32'(got.irq_clear));
          check_field("schedule_valid", 32'(want.schedule_valid), 32'(got.schedule_valid));
          check_field("schedule_count", want.schedule_count, got.schedule_count);
          check_field("status_changed", 32'(want.status_changed), 32'(got.status_changed));
          check_field("width_changed", 32'(want.width_changed), 32'(got.width_changed));
          check_field("frame_done", 32'(want.frame_done), 32'(got.frame_done));
        end
      end
      case (rx_phase[9:8])
        2'd0: m_axis_tready <= 1'b1;
        2'd1: m_axis_tready <= ($urandom_range(0, 1) == 0);
        2'd2: m_axis_tready <= (rx_phase[2:0] == 3'd0);
        default: m_axis_tready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[video_interface_timing_registers_unit] ERROR");
      $finish;
    end
  end

  initial begin
    logic [CLK_HZ_W-1:0] hz_set   [PHASE_COUNT];
    logic [RATE_W-1:0]   rate_set [PHASE_COUNT];
    hz_set   = '{27'd48681812, 27'd1, 27'd100000000, 27'h7FF_FFFF, 27'd0, 27'd50000000, 27'd0};
    rate_set = '{7'd60, 7'd1, 7'd120, 7'd127, 7'd0, 7'd50, 7'd0};
    cfg_we        <= 1'b0;
    cfg_addr      <= '0;
    cfg_wdata     <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= '0;
    rx_phase      = 0;
    cycle_count   = 0;
    fail_count    = 0;
    beats_checked = 0;
    line_reads    = 0;
    vsync_writes  = 0;
    ticks         = 0;
    requests      = 0;
    valid_held    = 1'b0;
    burst_left    = $urandom_range(1, 8);
    foreach (reg_shadow[i]) reg_shadow[i] = '0;
    field_bit   = 1'b0;
    frame_span  = '0;
    next_frame  = '0;
    line_cycles = '0;
    clk_hz      = CLK_HZ_RESET;
    fps         = REFRESH_RESET;

    // directed table: reset state, index edges, masks, vsync corners
    directed_rows = '{
      '{REQ_READ,  4'd0,  32'd0,        32'd0,        32'd0,         1'b1, RES_NONE},
      '{REQ_READ,  4'd4,  32'd0,        32'd0,        32'd0,         1'b1, RES_NONE},
      '{REQ_TICK,  4'd0,  32'd0,        32'd0,        32'd0,         1'b1, RES_TICK_AT_ZERO},
      '{REQ_NOP,   4'd15, ALL_ONES,     ALL_ONES,     ALL_ONES,      1'b1, RES_NONE},
      '{REQ_WRITE, 4'd15, ALL_ONES,     ALL_ONES,     32'd7,         1'b1, RES_NONE},
      '{REQ_WRITE, 4'd14, ALL_ONES,     ALL_ONES,     32'd7,         1'b1, RES_NONE},
      '{REQ_READ,  4'd15, 32'd0,        32'd0,        32'd0,         1'b1, RES_NONE},
      '{REQ_WRITE, 4'd0,  32'h40,       ALL_ONES,     32'd0,         1'b1, RES_STATUS_CHG},
      '{REQ_WRITE, 4'd0,  32'h40,       ALL_ONES,     32'd0,         1'b1, RES_NONE},
      '{REQ_WRITE, 4'd2,  ALL_ONES,     32'h0000FFFF, 32'd0,         1'b1, RES_WIDTH_CHG},
      '{REQ_READ,  4'd2,  32'd0,        32'd0,        32'd0,         1'b1,
        '{read_data: 32'h0000FFFF, default: '0}},
      '{REQ_WRITE, 4'd13, ALL_ONES,     32'hF0F0F0F0, 32'd0,         1'b1, RES_NONE},
      '{REQ_READ,  4'd13, 32'd0,        32'd0,        32'd0,         1'b1,
        '{read_data: 32'hF0F0F0F0, default: '0}},
      '{REQ_WRITE, 4'd4,  ALL_ONES,     ALL_ONES,     32'd0,         1'b1, RES_IRQ_CLEAR},
      '{REQ_READ,  4'd1,  32'd0,        32'd0,        32'd0,         1'b1, RES_NONE},
      '{REQ_WRITE, 4'd6,  32'd525,      ALL_ONES,     32'hFFFFFF00,  1'b0, RES_NONE},
      '{REQ_READ,  4'd4,  32'd0,        32'd0,        32'h00049000,  1'b0, RES_NONE},
      '{REQ_TICK,  4'd0,  32'd0,        32'd0,        32'd0,         1'b0, RES_NONE},
      '{REQ_READ,  4'd4,  32'd0,        32'd0,        ALL_ONES,      1'b0, RES_NONE},
      '{REQ_WRITE, 4'd0,  32'd0,        32'h40,       32'd0,         1'b1, RES_STATUS_CHG},
      '{REQ_WRITE, 4'd6,  ALL_ONES,     ALL_ONES,     32'd0,         1'b0, RES_NONE},
      '{REQ_READ,  4'd4,  32'd0,        32'd0,        32'h12345678,  1'b0, RES_NONE},
      '{REQ_WRITE, 4'd6,  32'd0,        32'd0,        32'd0,         1'b0, RES_NONE},
      '{REQ_WRITE, 4'd6,  32'd0,        ALL_ONES,     32'd0,         1'b0, RES_NONE},
      '{REQ_READ,  4'd4,  32'd0,        32'd0,        32'd0,         1'b0, RES_NONE},
      '{REQ_READ,  4'd6,  32'd0,        32'd0,        32'd0,         1'b0, RES_NONE}
    };

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[r])
      push_request(directed_rows[r].kind, directed_rows[r].idx, directed_rows[r].data,
                   directed_rows[r].mask, directed_rows[r].now, directed_rows[r].typed,
                   directed_rows[r].want);

    // random phases, timing settings changed only while idle
    for (int p = 0; p < PHASE_COUNT; p++) begin
      wait_idle();
      if (p == PHASE_COUNT - 1)
        set_timing(CLK_HZ_W'($urandom_range(1, 100000000)), RATE_W'($urandom_range(1, 120)));
      else
        set_timing(hz_set[p], rate_set[p]);
      for (int n = 0; n < PHASE_ITEMS; n++) random_request();
    end

    wait_idle();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("ran %0d requests over %0d timing settings: %0d line reads, %0d vsync writes,",
             requests, PHASE_COUNT, line_reads, vsync_writes);
    $display("%0d ticks; %0d result beats compared field by field", ticks, beats_checked);
    if (fail_count == 0) begin
      $display("[video_interface_timing_registers_unit] OK");
    end else begin
      $display("[video_interface_timing_registers_unit] ERROR");
    end
    $finish;
  end

endmodule
